FILE: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types, constants and helper functions of the spectrum band averager.
// ----------------------------------------------------------------------------
package sba_pkg;

   // Default sizes
   localparam int BAND_COUNT_DEF = 128;
   localparam int FFT_SIZE_DEF   = 1024;

   // Widest bin index (FFT_SIZE up to 8192) and band counter (up to 256 bands)
   localparam int KMAX_W = 13;
   localparam int EXP_W  = 4;
   localparam int BAND_W = 8;

   // ln(2) in Q0.30
   localparam logic [29:0] LN2_Q30 = 30'd744261118;

   // Band gains, Q1.8
   localparam logic [8:0] GAIN_LOW  = 9'd128;
   localparam logic [8:0] GAIN_MID  = 9'd205;
   localparam logic [8:0] GAIN_HIGH = 9'd307;
   localparam logic [8:0] GAIN_REST = 9'd384;

   // Register indexes
   localparam logic [1:0] CSR_FIRST_BIN     = 2'd0;
   localparam logic [1:0] CSR_BINS_PER_BAND = 2'd1;
   localparam logic [1:0] CSR_NORM_SCALE    = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [31:0] bin_re;
      logic signed [31:0] bin_im;
      logic               frame_start;
   } sba_req_type;

   typedef struct packed {
      logic [6:0]  band_index;
      logic [31:0] band_value;
      logic        last_band;
      logic        saturated;
   } sba_rsp_type;

   typedef struct packed {
      logic [9:0]  first_bin;
      logic [9:0]  bins_per_band;
      logic [31:0] norm_scale;
   } sba_cfg_type;

   // One classified bin handed from front to back
   typedef struct packed {
      logic [31:0]       re_mag;
      logic [31:0]       im_mag;
      logic [KMAX_W-1:0] bin_idx;
      logic [BAND_W-1:0] band;
      logic              close;
      logic              last;
      logic              clear;
   } sba_job_type;

   typedef enum logic [3:0] {
      EX_IDLE,
      EX_SQ_RE,
      EX_SQ_IM,
      EX_ITER,
      EX_LN,
      EX_LNSQ,
      EX_WEIGHT,
      EX_NORM_HI,
      EX_NORM_LO,
      EX_GAIN,
      EX_OUT
   } sba_ex_state_type;

   // Position of the leading one
   function automatic logic [EXP_W-1:0] msb_pos(input logic [KMAX_W-1:0] k);
      logic [EXP_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < KMAX_W; i++) begin
         if (k[i]) pos = EXP_W'(i);
      end
      return pos;
   endfunction

   // Gain by band range
   function automatic logic [8:0] band_gain(input logic [BAND_W-1:0] band);
      logic [8:0] g;
      if (band < BAND_W'(20))                               g = GAIN_LOW;
      else if (band < BAND_W'(40))                          g = GAIN_MID;
      else if (band >= BAND_W'(70) && band < BAND_W'(90))   g = GAIN_HIGH;
      else                                                  g = GAIN_REST;
      return g;
   endfunction

   // Two's complement magnitude
   function automatic logic [31:0] abs32(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

endpackage

FILE: rtl/sba_front.sv
// ----------------------------------------------------------------------------
// sba_front
// Accepts bins, tracks bin/band counters and the spectrum-done flag, forms the
// absolute bin index and pushes one job per kept bin into the queue.
// ----------------------------------------------------------------------------
module sba_front #(
   parameter int BAND_COUNT = sba_pkg::BAND_COUNT_DEF,
   parameter int FFT_SIZE   = sba_pkg::FFT_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sba_pkg::sba_req_type req_word,
   input  sba_pkg::sba_cfg_type cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output sba_pkg::sba_job_type q_job
);
   import sba_pkg::*;

   localparam int BW   = $clog2(BAND_COUNT);
   localparam int KW   = $clog2(FFT_SIZE);
   localparam int KSUM = BW + 12;
   localparam logic [KSUM-1:0] K_LAST = KSUM'(FFT_SIZE - 1);
   localparam logic [BW-1:0]   B_LAST = BW'(BAND_COUNT - 1);

   logic [9:0]    bin_ff, bin_in;
   logic [BW-1:0] band_ff, band_in;
   logic          done_ff, done_in;

   logic [9:0]      bin_c, bpb;
   logic [BW-1:0]   band_c;
   logic            done_c, accept, close;
   logic [KSUM-1:0] k_full;
   logic [KW-1:0]   k_sat;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Frame start clears counters before this bin
   assign bin_c  = req_word.frame_start ? '0 : bin_ff;
   assign band_c = req_word.frame_start ? '0 : band_ff;
   assign done_c = req_word.frame_start ? 1'b0 : done_ff;
   assign bpb    = (cfg.bins_per_band == '0) ? 10'd1 : cfg.bins_per_band;
   assign close  = ({1'b0, bin_c} + 11'd1) >= {1'b0, bpb};

   // Absolute bin index, clipped to FFT_SIZE - 1
   assign k_full = KSUM'(cfg.first_bin) + KSUM'(band_c * bpb) + KSUM'(bin_c);
   assign k_sat  = (k_full > K_LAST) ? K_LAST[KW-1:0] : k_full[KW-1:0];

   always_comb begin
      q_job.re_mag  = abs32(req_word.bin_re);
      q_job.im_mag  = abs32(req_word.bin_im);
      q_job.bin_idx = KMAX_W'(k_sat);
      q_job.band    = BAND_W'(band_c);
      q_job.close   = close;
      q_job.last    = (band_c == B_LAST);
      q_job.clear   = req_word.frame_start;
   end
   assign q_push = accept && !done_c;

   // Counter update
   always_comb begin
      bin_in  = bin_ff;
      band_in = band_ff;
      done_in = done_ff;
      if (accept) begin
         bin_in  = bin_c;
         band_in = band_c;
         done_in = done_c;
         if (!done_c) begin
            if (close) begin
               bin_in = '0;
               if (band_c >= B_LAST) done_in = 1'b1;
               else                  band_in = band_c + BW'(1);
            end else begin
               bin_in = bin_c + 10'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff  <= '0;
         band_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         bin_ff  <= bin_in;
         band_ff <= band_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: rtl/sba_queue.sv
// ----------------------------------------------------------------------------
// sba_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module sba_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sba_pkg::sba_job_type push_job,
   input  logic                 pop,
   output sba_pkg::sba_job_type head_job,
   output logic                 full,
   output logic                 empty
);
   import sba_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   sba_job_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]        cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PW + 1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = slot_ff[rd_ff];

   // Pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in  = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         cnt_in = cnt_in + (PW + 1)'(1);
      end
      if (pop && !empty) begin
         rd_in  = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         cnt_in = cnt_in - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push && !full) slot_ff[wr_ff] <= push_job;
   end

endmodule

FILE: rtl/sba_exec.sv
// ----------------------------------------------------------------------------
// sba_exec
// Back end: magnitude by bit-serial square root, ln^2 weight by repeated
// squaring, band accumulation, normalization, gain and the result register.
// ----------------------------------------------------------------------------
module sba_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  sba_pkg::sba_cfg_type cfg,
   input  logic                 q_empty,
   input  sba_pkg::sba_job_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sba_pkg::sba_rsp_type rsp_word
);
   import sba_pkg::*;

   localparam logic [47:0] ACC_MAX = '1;

   sba_ex_state_type state_ff, state_in;
   sba_job_type      job_ff, job_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [63:0]      rem_ff, rem_in, root_ff, root_in;
   logic [30:0]      m_ff, m_in;
   logic [29:0]      frac_ff, frac_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic [34:0]      ln30_ff, ln30_in;
   logic [25:0]      lnsq_ff, lnsq_in;
   logic [47:0]      acc_ff, acc_in;
   logic [63:0]      prod_ff, prod_in;
   logic [48:0]      avg_ff, avg_in;
   logic             out_v_ff, out_v_in;
   sba_rsp_type      out_ff, out_in;

   logic [63:0]             bit_w, try_w;
   logic [61:0]             msq;
   logic [31:0]             mtop;
   logic [KMAX_W+29:0]      m_shift;
   logic [59:0]             frac_prod;
   logic [20:0]             ln16;
   logic [41:0]             ln16_sq;
   logic [57:0]             wprod;
   logic [48:0]             acc_sum;
   logic [47:0]             acc_base;
   logic [64:0]             norm_sum;
   logic [47:0]             lo_prod;
   logic [57:0]             gprod;
   logic                    slot_free;

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;
   assign slot_free = !out_v_ff || !rsp_stall;

   // Datapath helpers
   assign bit_w     = 64'd1 << (6'd62 - {cnt_ff, 1'b0});
   assign try_w     = root_ff + bit_w;
   assign msq       = m_ff * m_ff;
   assign mtop      = msq[61:30];
   assign m_shift   = {q_head.bin_idx, 30'd0} >> msb_pos(q_head.bin_idx);
   assign frac_prod = frac_ff * LN2_Q30;
   assign ln16      = 21'((ln30_ff + 35'd8192) >> 14);
   assign ln16_sq   = ln16 * ln16 + 42'd32768;
   assign wprod     = root_ff[31:0] * lnsq_ff;
   assign acc_base  = job_ff.clear ? '0 : acc_ff;
   assign acc_sum   = {1'b0, acc_base} + 49'(wprod[57:16]);
   assign lo_prod   = acc_ff[15:0] * cfg.norm_scale;
   assign norm_sum  = {1'b0, prod_ff} + 65'(lo_prod[47:16]);
   assign gprod     = avg_ff * band_gain(job_ff.band);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      ln30_in  = ln30_ff;
      lnsq_in  = lnsq_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      avg_in   = avg_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_in   = out_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         EX_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               e_in     = msb_pos(q_head.bin_idx);
               m_in     = m_shift[30:0];
               frac_in  = '0;
               root_in  = '0;
               state_in = EX_SQ_RE;
            end
         end
         EX_SQ_RE: begin
            rem_in   = job_ff.re_mag * job_ff.re_mag;
            state_in = EX_SQ_IM;
         end
         EX_SQ_IM: begin
            rem_in   = rem_ff + job_ff.im_mag * job_ff.im_mag;
            cnt_in   = '0;
            state_in = EX_ITER;
         end
         EX_ITER: begin
            // one root bit per cycle, plus one log2 fraction bit per cycle until the fraction is full
            if (rem_ff >= try_w) begin
               rem_in  = rem_ff - try_w;
               root_in = (root_ff >> 1) + bit_w;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff < 5'd30) begin
               if (mtop[31]) begin
                  m_in    = mtop[31:1];
                  frac_in = {frac_ff[28:0], 1'b1};
               end else begin
                  m_in    = mtop[30:0];
                  frac_in = {frac_ff[28:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = EX_LN;
         end
         EX_LN: begin
            ln30_in  = 35'(e_ff * LN2_Q30) + 35'(frac_prod[59:30]);
            state_in = EX_LNSQ;
         end
         EX_LNSQ: begin
            lnsq_in  = (job_ff.bin_idx == '0) ? '0 : ln16_sq[41:16];
            state_in = EX_WEIGHT;
         end
         EX_WEIGHT: begin
            acc_in   = acc_sum[48] ? ACC_MAX : acc_sum[47:0];
            state_in = job_ff.close ? EX_NORM_HI : EX_IDLE;
         end
         EX_NORM_HI: begin
            prod_in  = acc_ff[47:16] * cfg.norm_scale;
            state_in = EX_NORM_LO;
         end
         EX_NORM_LO: begin
            avg_in   = norm_sum[64:16];
            state_in = EX_GAIN;
         end
         EX_GAIN: begin
            acc_in   = '0;
            state_in = EX_OUT;
         end
         EX_OUT: begin
            // band word enters the result register once it is free
            if (slot_free) begin
               out_in.band_index = job_ff.band[6:0];
               out_in.last_band  = job_ff.last;
               out_in.saturated  = |gprod[57:40];
               out_in.band_value = (|gprod[57:40]) ? '1 : gprod[39:8];
               out_v_in = 1'b1;
               state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
         acc_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         out_v_ff <= out_v_in;
      end
   end

   // Payload registers (out_ff only moves while the slot is free)
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      e_ff    <= e_in;
      ln30_ff <= ln30_in;
      lnsq_ff <= lnsq_in;
      prod_ff <= prod_in;
      avg_ff  <= avg_in;
      if (state_ff == EX_OUT && slot_free) out_ff <= out_in;
   end

endmodule

FILE: rtl/spectrum_band_averager_core.sv
// ----------------------------------------------------------------------------
// spectrum_band_averager_core
// Turns a stream of complex FFT bins into ln^2-weighted, gained band values.
// ----------------------------------------------------------------------------
// Each bin is squared, passes the 32-step bit-serial square root that forms the
// magnitude, and is then weighted and accumulated; a bin that closes a band also
// runs normalization and gain. The log2 fraction behind the ln^2 weight is
// formed beside the root by repeated squaring. A two-entry queue lets the input
// side take bins while the back end works, and a result register holds a
// finished band while the next bin is already being processed.
module spectrum_band_averager_core #(
   parameter int BAND_COUNT = sba_pkg::BAND_COUNT_DEF,
   parameter int FFT_SIZE   = sba_pkg::FFT_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sba_pkg::sba_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sba_pkg::sba_rsp_type rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import sba_pkg::*;

   sba_cfg_type cfg_ff, cfg_in;
   sba_job_type push_job, head_job;
   logic        q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIRST_BIN:     cfg_in.first_bin     = csr_wdata[9:0];
            CSR_BINS_PER_BAND: cfg_in.bins_per_band = csr_wdata[9:0];
            CSR_NORM_SCALE:    cfg_in.norm_scale    = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bin     <= 10'd1;
         cfg_ff.bins_per_band <= 10'd4;
         cfg_ff.norm_scale    <= 32'd2097152;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sba_front #(.BAND_COUNT(BAND_COUNT), .FFT_SIZE(FFT_SIZE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   sba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   sba_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Checks
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.saturated |-> rsp_word.band_value == 32'hFFFF_FFFF)
      else $error("saturated band without clipped value");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last_band |-> rsp_word.band_index == 7'(BAND_COUNT - 1))
      else $error("last band flag on wrong band index");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule
